// ----- rtl/skv_pkg.sv -----
// Package for the sorted key/value table: widths, action and status codes,
// and the key mask helper. Depends on nothing; the interfaces, the table and the checker import it.
package skv_pkg;

    localparam int DEPTH           = 64;
    localparam int MAX_KEY_BYTES   = 8;
    localparam int VALUE_BITS      = 32;
    localparam int KEY_W           = 64;
    localparam int KEY_BYTES_W     = 4;
    localparam int ACTION_W        = 3;
    localparam int STATUS_W        = 2;
    localparam int COUNT_W         = 7;
    localparam int ADDR_W          = $clog2(DEPTH);
    localparam int CNT_W           = $clog2(DEPTH + 1);
    localparam int ENTRY_W         = KEY_W + VALUE_BITS;
    localparam logic [KEY_BYTES_W-1:0] KEY_BYTES_RESET = KEY_BYTES_W'(MAX_KEY_BYTES);

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_FIND   = 3'd1,
        ACT_UPDATE = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    // Mask that keeps the low key bytes in force; zero acts as one byte and
    // anything above the maximum acts as the maximum.
    function automatic logic [KEY_W-1:0] key_mask(input logic [KEY_BYTES_W-1:0] kb);
        logic [KEY_BYTES_W-1:0] n;
        logic [KEY_W-1:0]       m;
        n = kb;
        if (n == '0)
        begin
            n = KEY_BYTES_W'(1);
        end
        if (n > KEY_BYTES_W'(MAX_KEY_BYTES))
        begin
            n = KEY_BYTES_W'(MAX_KEY_BYTES);
        end
        m = '0;
        for (int b = 0; b < MAX_KEY_BYTES; b++)
        begin
            if (KEY_BYTES_W'(b) < n)
            begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ----- rtl/skv_req_if.sv -----
// Request channel of the sorted key/value table: handshake and request fields.
// Depends on skv_pkg for the field widths.
interface skv_req_if import skv_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, action, key, value, input ready);
    modport sink   (input valid, action, key, value, output ready);

endinterface

// ----- rtl/skv_rsp_if.sv -----
// Response channel of the sorted key/value table: handshake and result fields.
// Depends on skv_pkg for the field widths.
interface skv_rsp_if import skv_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [VALUE_BITS-1:0] returned_value;
    logic [COUNT_W-1:0]    entry_count;

    modport source (output valid, status, returned_value, entry_count, input ready);
    modport sink   (input valid, status, returned_value, entry_count, output ready);

endinterface

// ----- rtl/sorted_key_value_table.sv -----
// Sorted key/value table; one request at a time, not ready while a request is in work.
// Insert, find, update and delete first search the entries in order; insert then shifts
// entries toward the end and a delete hit shifts them toward the front. Clear, an insert
// into a full table and unused actions go straight to the result. The next request is taken
// once back in idle; a held result stalls it. One RAM port pair moves one entry a cycle.
// Reset (rst_n low, asynchronous) empties the table and sets key_bytes to 8.
module sorted_key_value_table import skv_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [KEY_BYTES_W-1:0] cfg_wr_data,
    skv_req_if.sink                req,
    skv_rsp_if.source              rsp
);

    // The sequencer walks one RAM that holds each entry as {key, value}.
    // SEARCH reads entries in order, comparing each one the cycle after its
    // read, and stops at the first stored key that is not below the request
    // key. EXEC decides what the action does at that position. UP moves
    // entries one place toward the end, from the last one down to the
    // position, and then writes the new entry. DOWN moves entries one place
    // toward the front to close the gap of a deleted entry. RESP hands the
    // result to the output register, which may still hold an earlier result.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_EXEC,
        S_UP,
        S_DOWN,
        S_RESP
    } state_t;

    state_t                 state_reg,     state_next;
    logic [ACTION_W-1:0]    act_reg,       act_next;
    logic [KEY_W-1:0]       key_reg,       key_next;
    logic [VALUE_BITS-1:0]  val_reg,       val_next;
    logic [CNT_W-1:0]       idx_reg,       idx_next;
    logic                   pend_reg,      pend_next;
    logic [CNT_W-1:0]       pos_reg,       pos_next;
    logic                   hit_reg,       hit_next;
    logic [KEY_W-1:0]       hold_key_reg,  hold_key_next;
    logic [VALUE_BITS-1:0]  hold_val_reg,  hold_val_next;
    logic [ADDR_W-1:0]      wr_reg,        wr_next;
    logic [CNT_W-1:0]       fill_reg,      fill_next;
    logic [KEY_BYTES_W-1:0] kbytes_reg,    kbytes_next;
    status_t                res_status_reg, res_status_next;
    logic [VALUE_BITS-1:0]  res_val_reg,   res_val_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [VALUE_BITS-1:0]  out_val_reg,   out_val_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;

    // RAM port signals.
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;

    logic [KEY_W-1:0]       mask;
    logic [KEY_W-1:0]       rd_key;
    logic [VALUE_BITS-1:0]  rd_val;
    logic [KEY_W-1:0]       rd_key_m;
    logic [KEY_W-1:0]       req_key_m;
    logic                   search_stop;
    logic [CNT_W-1:0]       idx_inc;
    logic [CNT_W-1:0]       idx_dec;
    logic                   accept;

    skv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The key width in force is the one in the register now, so every
    // comparison masks both sides with it.
    assign mask      = key_mask(kbytes_reg);
    assign rd_key    = ram_rdata[ENTRY_W-1 -: KEY_W];
    assign rd_val    = ram_rdata[VALUE_BITS-1:0];
    assign rd_key_m  = rd_key & mask;
    assign req_key_m = key_reg & mask;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_dec   = idx_reg - CNT_W'(1);

    // The entry read last cycle is the first one whose key is not below the
    // request key, so the search ends there.
    assign search_stop = pend_reg && !(rd_key_m < req_key_m);

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.returned_value = out_val_reg;
    assign rsp.entry_count    = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        hold_key_next   = hold_key_reg;
        hold_val_next   = hold_val_reg;
        wr_next         = wr_reg;
        fill_next       = fill_reg;
        kbytes_next     = kbytes_reg;
        res_status_next = res_status_reg;
        res_val_next    = res_val_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_val_next    = out_val_reg;
        out_count_next  = out_count_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        if (cfg_wr_en)
        begin
            kbytes_next = cfg_wr_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next        = req.action;
                    key_next        = req.key;
                    val_next        = req.value;
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    res_status_next = STAT_OK;
                    res_val_next    = '0;
                    unique case (req.action)
                        ACT_INSERT:
                        begin
                            if (fill_reg == CNT_W'(DEPTH))
                            begin
                                res_status_next = STAT_FULL;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        ACT_FIND, ACT_UPDATE, ACT_DELETE:
                        begin
                            state_next = S_SEARCH;
                        end
                        ACT_CLEAR:
                        begin
                            fill_next  = '0;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (search_stop)
                begin
                    pos_next      = idx_dec;
                    hit_next      = (rd_key_m == req_key_m);
                    hold_key_next = rd_key;
                    hold_val_next = rd_val;
                    pend_next     = 1'b0;
                    state_next    = S_EXEC;
                end
                else if (idx_reg < fill_reg)
                begin
                    ram_raddr = idx_reg[ADDR_W-1:0];
                    idx_next  = idx_inc;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        // Every stored key is below the request key.
                        pos_next   = fill_reg;
                        hit_next   = 1'b0;
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                pend_next = 1'b0;
                unique case (act_reg)
                    ACT_INSERT:
                    begin
                        idx_next   = fill_reg;
                        state_next = S_UP;
                    end
                    ACT_FIND:
                    begin
                        if (hit_reg)
                        begin
                            res_val_next = hold_val_reg;
                        end
                        else
                        begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                        state_next = S_RESP;
                    end
                    ACT_UPDATE:
                    begin
                        if (hit_reg)
                        begin
                            // The stored key keeps all its bits.
                            ram_we       = 1'b1;
                            ram_waddr    = pos_reg[ADDR_W-1:0];
                            ram_wdata    = {hold_key_reg, val_reg};
                            res_val_next = hold_val_reg;
                        end
                        else
                        begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                        state_next = S_RESP;
                    end
                    ACT_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            res_val_next = hold_val_reg;
                            idx_next     = pos_reg + CNT_W'(1);
                            state_next   = S_DOWN;
                        end
                        else
                        begin
                            res_status_next = STAT_NOT_FOUND;
                            state_next      = S_RESP;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_UP:
            begin
                // Entry read last cycle lands one place further on.
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_reg;
                    ram_wdata = ram_rdata;
                end
                if (idx_reg > pos_reg)
                begin
                    ram_raddr = idx_dec[ADDR_W-1:0];
                    wr_next   = idx_reg[ADDR_W-1:0];
                    idx_next  = idx_dec;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = pos_reg[ADDR_W-1:0];
                        ram_wdata  = {key_reg, val_reg};
                        fill_next  = fill_reg + CNT_W'(1);
                        state_next = S_RESP;
                    end
                end
            end

            S_DOWN:
            begin
                // Entry read last cycle lands one place nearer the front.
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_reg;
                    ram_wdata = ram_rdata;
                end
                if (idx_reg < fill_reg)
                begin
                    ram_raddr = idx_reg[ADDR_W-1:0];
                    wr_next   = idx_dec[ADDR_W-1:0];
                    idx_next  = idx_inc;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        fill_next  = fill_reg - CNT_W'(1);
                        state_next = S_RESP;
                    end
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_val_next    = res_val_reg;
                    out_count_next  = COUNT_W'(fill_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_reg        <= '0;
            key_reg        <= '0;
            val_reg        <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            pos_reg        <= '0;
            hit_reg        <= 1'b0;
            hold_key_reg   <= '0;
            hold_val_reg   <= '0;
            wr_reg         <= '0;
            fill_reg       <= '0;
            kbytes_reg     <= KEY_BYTES_RESET;
            res_status_reg <= STAT_OK;
            res_val_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_OK;
            out_val_reg    <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            act_reg        <= act_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            pos_reg        <= pos_next;
            hit_reg        <= hit_next;
            hold_key_reg   <= hold_key_next;
            hold_val_reg   <= hold_val_next;
            wr_reg         <= wr_next;
            fill_reg       <= fill_next;
            kbytes_reg     <= kbytes_next;
            res_status_reg <= res_status_next;
            res_val_reg    <= res_val_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_val_reg    <= out_val_next;
            out_count_reg  <= out_count_next;
        end
    end

endmodule

// ----- rtl/skv_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module skv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/skv_checker.sv -----
// Port-level checks for the sorted key/value table, bound to the top level.
// Depends on skv_pkg and on sorted_key_value_table.
module skv_checker import skv_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [STATUS_W-1:0]   rsp_status,
    input logic [VALUE_BITS-1:0] rsp_returned_value,
    input logic [COUNT_W-1:0]    rsp_entry_count
);

    // A stalled result stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its fields.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_returned_value)
            && $stable(rsp_entry_count))
        else $error("result changed while stalled");

    // A new result only comes out of a request in work, never from idle.
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result appeared while the block was idle");

    // A full table reports a full count and no value.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STAT_FULL |->
            rsp_entry_count == COUNT_W'(DEPTH) && rsp_returned_value == '0)
        else $error("full status with wrong count or value");

endmodule

bind sorted_key_value_table skv_checker u_skv_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_returned_value (rsp.returned_value),
    .rsp_entry_count    (rsp.entry_count)
);
